### src/wiegand_frame_transmitter_top_assert.svh
// Assertion macros shared by the Wiegand transmitter modules.
`ifndef WIEGAND_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define WIEGAND_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wft assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wft assertion failed");

`endif

### src/wft_pkg.sv
// Shared types and constants of the Wiegand frame transmitter.
`timescale 1ns / 1ps
package wft_pkg;

	localparam int MAX_RAW_BITS    = 64;
	localparam int WFT_QUEUE_DEPTH = 2;

	localparam logic [16:0] LEAD_RESET  = 17'd82000;
	localparam logic [15:0] PULSE_RESET = 16'd50;
	localparam logic [15:0] GAP_RESET   = 16'd1000;
	localparam logic [16:0] TRAIL_RESET = 17'd10000;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SEND_FMT = 2'd1,
		ACT_SEND_RAW = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		FMT_26 = 2'd0,
		FMT_34 = 2'd1,
		FMT_37 = 2'd2
	} format_t;

	typedef enum logic [1:0] {
		REG_LEAD  = 2'd0,
		REG_PULSE = 2'd1,
		REG_GAP   = 2'd2,
		REG_TRAIL = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_REQ  = 2'd1,
		KIND_NOP  = 2'd2
	} kind_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] frame;
		logic [6:0]  len;
	} mid_item_t;

	// Result item.
	typedef struct packed {
		logic    d0_line;
		logic    d1_line;
		logic    busy_res;
		status_t request_status;
		logic    frame_done;
	} res_item_t;

endpackage

### src/wft_queue.sv
// Small register queue used between the front, back and result side.
`timescale 1ns / 1ps
`include "wiegand_frame_transmitter_top_assert.svh"
module wft_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`WFT_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(DEPTH))
	`WFT_ASSERT_NEXT(a_pop_drains, do_pop && !do_push, count_q == $past(count_q) - CW'(1))
endmodule

### src/wft_front.sv
// Front part: classifies an item and builds the left-aligned frame.
`timescale 1ns / 1ps
module wft_front (
	input  logic              [1:0]  action,
	input  logic              [1:0]  format,
	input  logic              [15:0] facility,
	input  logic              [18:0] card,
	input  logic              [63:0] raw_bits,
	input  logic              [6:0]  raw_length,
	output wft_pkg::mid_item_t       item
);
	import wft_pkg::*;

	logic [6:0]  raw_len;
	logic [6:0]  raw_shift;
	logic [63:0] fmt_frame;
	logic [6:0]  fmt_len;

	always_comb begin
		raw_len   = (raw_length > 7'(MAX_RAW_BITS)) ? 7'(MAX_RAW_BITS) : raw_length;
		raw_shift = 7'd64 - raw_len;
	end

	always_comb begin
		unique case (format)
			FMT_26: begin
				fmt_frame = {^{facility[7:0], card[15:12]}, facility[7:0], card[15:0],
					~^card[11:0], 38'd0};
				fmt_len = 7'd26;
			end
			FMT_34: begin
				fmt_frame = {^facility, facility, card[15:0], ~^card[15:0], 30'd0};
				fmt_len = 7'd34;
			end
			default: begin
				fmt_frame = {^{facility, card[18:17]}, facility, card, ~^card[16:0], 27'd0};
				fmt_len = 7'd37;
			end
		endcase
	end

	always_comb begin
		item.frame = fmt_frame;
		item.len   = fmt_len;
		unique case (action)
			ACT_TICK: item.kind = KIND_TICK;
			ACT_SEND_FMT: item.kind = KIND_REQ;
			ACT_SEND_RAW: begin
				item.kind  = KIND_REQ;
				item.frame = (raw_len == '0) ? '0 : (raw_bits << raw_shift);
				item.len   = raw_len;
			end
			default: item.kind = KIND_NOP;
		endcase
	end
endmodule

### src/wft_back.sv
// Back part: frame sequencer with the timing registers.
`timescale 1ns / 1ps
`include "wiegand_frame_transmitter_top_assert.svh"
module wft_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  wft_pkg::mid_item_t        item,
	output wft_pkg::res_item_t        res,
	input  logic                      cfg_write,
	input  logic               [1:0]  cfg_index,
	input  logic               [16:0] cfg_data
);
	import wft_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_PULSE,
		PH_GAP,
		PH_TRAIL
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [63:0] shift_q, shift_d;
	logic [6:0]  bits_q, bits_d;
	logic [16:0] timer_q, timer_d;
	logic [16:0] lead_q;
	logic [15:0] pulse_q;
	logic [15:0] gap_q;
	logic [16:0] trail_q;
	logic [16:0] pulse_eff;
	status_t     status;
	logic        done;

	assign pulse_eff = (pulse_q == '0) ? 17'd1 : {1'b0, pulse_q};

	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		timer_d = timer_q;
		status  = ST_NONE;
		done    = 1'b0;
		if (step) begin
			unique case (item.kind)
				KIND_REQ: begin
					if (phase_q != PH_IDLE) begin
						status = ST_REJECTED;
					end else begin
						status  = ST_ACCEPTED;
						shift_d = item.frame;
						bits_d  = item.len;
						priority if (lead_q != '0) begin
							phase_d = PH_LEAD;
							timer_d = lead_q;
						end else if (item.len != '0) begin
							phase_d = PH_PULSE;
							timer_d = pulse_eff;
						end else if (trail_q != '0) begin
							phase_d = PH_TRAIL;
							timer_d = trail_q;
						end else begin
							phase_d = PH_IDLE;
							timer_d = '0;
							done    = 1'b1;
						end
					end
				end
				KIND_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (timer_q > 17'd1) begin
							timer_d = timer_q - 17'd1;
						end else begin
							unique case (phase_q)
								PH_LEAD: begin
									priority if (bits_q != '0) begin
										phase_d = PH_PULSE;
										timer_d = pulse_eff;
									end else if (trail_q != '0) begin
										phase_d = PH_TRAIL;
										timer_d = trail_q;
									end else begin
										phase_d = PH_IDLE;
										timer_d = '0;
										done    = 1'b1;
									end
								end
								PH_PULSE: begin
									shift_d = shift_q << 1;
									bits_d  = bits_q - 7'd1;
									priority if (bits_q != 7'd1 && gap_q != '0) begin
										phase_d = PH_GAP;
										timer_d = {1'b0, gap_q};
									end else if (bits_q != 7'd1) begin
										phase_d = PH_PULSE;
										timer_d = pulse_eff;
									end else if (trail_q != '0) begin
										phase_d = PH_TRAIL;
										timer_d = trail_q;
									end else begin
										phase_d = PH_IDLE;
										timer_d = '0;
										done    = 1'b1;
									end
								end
								PH_GAP: begin
									phase_d = PH_PULSE;
									timer_d = pulse_eff;
								end
								default: begin
									phase_d = PH_IDLE;
									timer_d = '0;
									done    = 1'b1;
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.d0_line        = !(phase_d == PH_PULSE && !shift_d[63]);
		res.d1_line        = !(phase_d == PH_PULSE && shift_d[63]);
		res.busy_res       = (phase_d != PH_IDLE);
		res.request_status = status;
		res.frame_done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			timer_q <= '0;
			lead_q  <= LEAD_RESET;
			pulse_q <= PULSE_RESET;
			gap_q   <= GAP_RESET;
			trail_q <= TRAIL_RESET;
		end else begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			timer_q <= timer_d;
			if (cfg_write) begin
				unique case (reg_index_t'(cfg_index))
					REG_LEAD: lead_q <= cfg_data;
					REG_PULSE: pulse_q <= cfg_data[15:0];
					REG_GAP: gap_q <= cfg_data[15:0];
					REG_TRAIL: trail_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	`WFT_ASSERT_NOW(a_timer_live, phase_q != PH_IDLE, timer_q != '0)
	`WFT_ASSERT_NOW(a_pulse_bits, phase_q == PH_PULSE, bits_q != '0)
	`WFT_ASSERT_NOW(a_done_idle, step && done, phase_d == PH_IDLE)
endmodule

### src/wiegand_frame_transmitter_top.sv
// Top level of the Wiegand frame transmitter.
// Usage:
// Input items enter through push/full: an item is taken on a clock edge with push high
// and full low. Action 0 is one time tick, action 1 sends a formatted 26, 34 or 37 bit
// frame, action 2 sends up to 64 raw bits. A request made while a frame is running is
// rejected and reported in request_status.
// Every item gives exactly one result item, read through empty/pop: the oldest result
// is on the ports while empty is low and is taken on an edge with pop high.
// The result of an item shows the line levels after that item.
// A result passes through the input queue, the sequencer step in the back part and the
// result queue to the ports; one item per cycle is sustained while the result queue is not full.
// When the receiver stalls, the result queue and then the input queue fill and full
// rises; nothing is lost. Each queue holds QUEUE_DEPTH items.
// Timing registers are written through cfg_valid/cfg_ready, always ready; the user must
// write them only while idle (not enforced by the block). Reset clears both queues, puts
// the sequencer in idle with both lines high and restores the default timing registers.
`timescale 1ns / 1ps
module wiegand_frame_transmitter_top #(
	parameter int QUEUE_DEPTH = wft_pkg::WFT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [1:0]  format,
	input  logic [15:0] facility,
	input  logic [18:0] card,
	input  logic [63:0] raw_bits,
	input  logic [6:0]  raw_length,
	output logic        empty,
	input  logic        pop,
	output logic        d0_line,
	output logic        d1_line,
	output logic        busy_res,
	output logic [1:0]  request_status,
	output logic        frame_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import wft_pkg::*;

	mid_item_t front_item;
	mid_item_t mid_item;
	res_item_t back_res;
	res_item_t out_res;
	logic      mid_empty;
	logic      out_full;
	logic      step;

	assign cfg_ready = 1'b1;
	assign step      = !mid_empty && !out_full;

	wft_front u_front (
		.action     (action),
		.format     (format),
		.facility   (facility),
		.card       (card),
		.raw_bits   (raw_bits),
		.raw_length (raw_length),
		.item       (front_item)
	);

	wft_queue #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_item),
		.full    (full),
		.pop     (step),
		.rd_data (mid_item),
		.empty   (mid_empty)
	);

	wft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (mid_item),
		.res       (back_res),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wft_queue #(
		.WIDTH ($bits(res_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (step),
		.wr_data (back_res),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign d0_line        = out_res.d0_line;
	assign d1_line        = out_res.d1_line;
	assign busy_res       = out_res.busy_res;
	assign request_status = out_res.request_status;
	assign frame_done     = out_res.frame_done;
endmodule
